FILE: src/assert_macros.svh
// assertion macros for the lfo wave table blocks, included by lfo_wave_table_sample
// expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define LWS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LWS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lws_pkg.sv
// package for the lfo wave table entry generator
// widths, shape and register codes, sideband item type; no dependencies
package lws_pkg;

  localparam int SLOT_W     = 3;
  localparam int IDX_W      = 9;
  localparam int AMP_W      = 16;
  localparam int SHAPE_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // dividend, divisor and quotient widths of the divider chain
  localparam int NW = 62;
  localparam int DW = 45;
  localparam int QW = 17;

  localparam int MAX_ENTRIES_DEF = 512;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SINE2 = 3'd0,
    SHAPE_TRI   = 3'd1,
    SHAPE_UP    = 3'd2,
    SHAPE_DOWN  = 3'd3,
    SHAPE_TRAP  = 3'd4,
    SHAPE_SUP   = 3'd5,
    SHAPE_SDOWN = 3'd6,
    SHAPE_EXP   = 3'd7
  } shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE = 2'd0,
    CFG_LAST  = 2'd1,
    CFG_PEAK  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  idx;
    logic [AMP_W-1:0]  amp;
    logic              invert;
    logic              force_amp;
    logic              zero;
  } side_t;

endpackage

FILE: src/lws_in_if.sv
// input item channel: table slot and entry index
// depends on lws_pkg
interface lws_in_if;
  import lws_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] table_slot;
  logic [IDX_W-1:0]  entry_index;

  modport source (output valid, table_slot, entry_index, input ready);
  modport sink (input valid, table_slot, entry_index, output ready);
endinterface

FILE: src/lws_out_if.sv
// result item channel: slot and index echo with the sample value
// depends on lws_pkg
interface lws_out_if;
  import lws_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_out;
  logic [IDX_W-1:0]  index_out;
  logic [AMP_W-1:0]  sample_value;

  modport source (output valid, slot_out, index_out, sample_value, input ready);
  modport sink (input valid, slot_out, index_out, sample_value, output ready);
endinterface

FILE: src/lfo_wave_table_sample.sv
// from the accepting edge to the result item: 5 front end stages, 17 divider
// cells, 1 output register; throughput one item per cycle while item_out.ready
// does not hold the output register; one quotient bit per divider cell
// reset (rst, synchronous): pipeline emptied, wave_shape 0, table_last 511,
// peak_amplitude 65535; depends on lws_pkg, lws_in_if, lws_out_if, lws_prep,
// lws_div_cell
`include "assert_macros.svh"

module lfo_wave_table_sample #(
  parameter int MAX_ENTRIES = lws_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  lws_in_if.sink                         item_in,
  lws_out_if.source                      item_out,
  input  logic                           cfg_we,
  input  logic [lws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lws_pkg::*;

  shape_t           wave_shape;
  logic [IDX_W-1:0] table_last;
  logic [AMP_W-1:0] peak_amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape     <= SHAPE_SINE2;
      table_last     <= '1;
      peak_amplitude <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHAPE: wave_shape     <= shape_t'(cfg_data[SHAPE_W-1:0]);
        CFG_LAST:  table_last     <= cfg_data[IDX_W-1:0];
        CFG_PEAK:  peak_amplitude <= cfg_data[AMP_W-1:0];
        default:   ;
      endcase
    end
  end

  logic          cv [QW+1];
  logic          cr [QW+1];
  logic [NW-1:0] crem [QW+1];
  logic [DW-1:0] cden [QW+1];
  logic [QW-1:0] cquo [QW+1];
  side_t         cside [QW+1];

  lws_prep #(.MAX_ENTRIES(MAX_ENTRIES)) u_prep (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (item_in.valid),
    .in_ready       (item_in.ready),
    .table_slot     (item_in.table_slot),
    .entry_index    (item_in.entry_index),
    .wave_shape     (wave_shape),
    .table_last     (table_last),
    .peak_amplitude (peak_amplitude),
    .out_valid      (cv[0]),
    .out_ready      (cr[0]),
    .num            (crem[0]),
    .den            (cden[0]),
    .side           (cside[0])
  );

  assign cquo[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    lws_div_cell #(.BIT(QW - 1 - i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .rem_in    (crem[i]),
      .den_in    (cden[i]),
      .quo_in    (cquo[i]),
      .side_in   (cside[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .rem_out   (crem[i+1]),
      .den_out   (cden[i+1]),
      .quo_out   (cquo[i+1]),
      .side_out  (cside[i+1])
    );
  end

  // output register
  side_t            fs;
  logic [QW-1:0]    yq;
  logic [AMP_W-1:0] y_c;
  logic             ov;
  logic [AMP_W-1:0] amp_o;

  always_comb begin
    fs = cside[QW];
    yq = fs.invert ? QW'({1'b0, fs.amp} - cquo[QW]) : cquo[QW];
    if (fs.zero) y_c = '0;
    else if (fs.force_amp || yq > QW'(fs.amp)) y_c = fs.amp;
    else y_c = yq[AMP_W-1:0];
  end

  assign cr[QW] = !ov || item_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (cr[QW]) begin
      ov <= cv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[QW]) begin
      item_out.slot_out     <= fs.slot;
      item_out.index_out    <= fs.idx;
      item_out.sample_value <= y_c;
      amp_o                 <= fs.amp;
    end
  end

  assign item_out.valid = ov;

  `LWS_ASSERT(a_below_peak, ov |-> item_out.sample_value <= amp_o, "sample above peak")
  `LWS_ASSERT(a_ready_when_empty, !ov |-> item_in.ready, "input stalled with empty output")
  `LWS_ASSERT_ALWAYS(a_reset_empty, rst |=> !ov, "output valid after reset")

endmodule

FILE: src/lws_prep.sv
// five stage front end: clamps the index, forms the shape polynomials
// and hands a dividend and divisor to the divider chain; depends on lws_pkg
module lws_prep #(
  parameter int MAX_ENTRIES = lws_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lws_pkg::SLOT_W-1:0]  table_slot,
  input  logic [lws_pkg::IDX_W-1:0]   entry_index,
  input  lws_pkg::shape_t             wave_shape,
  input  logic [lws_pkg::IDX_W-1:0]   table_last,
  input  logic [lws_pkg::AMP_W-1:0]   peak_amplitude,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lws_pkg::NW-1:0]      num,
  output logic [lws_pkg::DW-1:0]      den,
  output lws_pkg::side_t              side
);
  import lws_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_ENTRIES - 1);

  logic [4:0] v;
  logic [5:0] rdy;

  assign rdy[5] = out_ready;
  for (genvar k = 0; k < 5; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0
  logic [IDX_W-1:0] n_c, x_c, nmx_c, t_c;
  logic [IDX_W:0]   x2_c;
  logic [IDX_W+1:0] x4_c, n3_c;
  logic             half_c, inv_c, force_c;
  logic [IDX_W+1:0] m_c;

  always_comb begin
    n_c    = (table_last > LAST) ? LAST : table_last;
    x_c    = (entry_index > n_c) ? n_c : entry_index;
    nmx_c  = n_c - x_c;
    x2_c   = {x_c, 1'b0};
    half_c = x2_c <= {1'b0, n_c};
    t_c    = half_c ? x2_c[IDX_W-1:0] : IDX_W'(x2_c - {1'b0, n_c});
    x4_c   = {x_c, 2'b00};
    n3_c   = {2'b00, n_c} + {1'b0, n_c, 1'b0};
    m_c    = '0;
    inv_c  = 1'b0;
    force_c = 1'b0;
    case (wave_shape)
      SHAPE_TRI:   m_c = half_c ? {1'b0, x2_c} : {1'b0, nmx_c, 1'b0};
      SHAPE_UP:    m_c = {2'b00, x_c};
      SHAPE_DOWN:  m_c = {2'b00, nmx_c};
      SHAPE_TRAP: begin
        if (x4_c < {2'b00, n_c}) m_c = x4_c;
        else if (x4_c <= n3_c) force_c = 1'b1;
        else m_c = {nmx_c, 2'b00};
      end
      SHAPE_SDOWN: inv_c = 1'b1;
      SHAPE_EXP:   inv_c = !half_c;
      default:     m_c = '0;
    endcase
  end

  side_t            side0;
  shape_t           shp0;
  logic [IDX_W-1:0] x0, n0, t0;
  logic [IDX_W+1:0] m0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side0 <= '{slot: table_slot, idx: entry_index, amp: peak_amplitude,
                 invert: inv_c, force_amp: force_c, zero: (n_c == '0)};
      shp0  <= wave_shape;
      x0    <= x_c;
      n0    <= n_c;
      t0    <= t_c;
      m0    <= m_c;
    end
  end

  // stage 1
  side_t            side1;
  shape_t           shp1;
  logic [IDX_W-1:0] x1, n1, t1;
  logic [17:0]      xx1, nn1, q1, tt1;
  logic [26:0]      am1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side1 <= side0;
      shp1  <= shp0;
      x1    <= x0;
      n1    <= n0;
      t1    <= t0;
      xx1   <= 18'(x0) * 18'(x0);
      nn1   <= 18'(n0) * 18'(n0);
      q1    <= 18'(x0) * 18'(n0 - x0);
      tt1   <= 18'(t0) * 18'(t0);
      am1   <= 27'(side0.amp) * 27'(m0);
    end
  end

  // stage 2
  logic [21:0] num_c;
  logic [20:0] den_c;
  logic [10:0] k_c;

  always_comb begin
    num_c = {q1, 4'b0000};
    den_c = 21'({nn1, 2'b00}) + 21'(nn1) - 21'({q1, 2'b00});
    k_c   = 11'({n1, 1'b0}) + 11'(n1) - 11'({x1, 1'b0});
  end

  side_t            side2;
  shape_t           shp2;
  logic [IDX_W-1:0] n2, t2;
  logic [26:0]      am2;
  logic [43:0]      num2;
  logic [41:0]      den2;
  logic [28:0]      c5;
  logic [26:0]      n3;
  logic [35:0]      t4, n4;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      side2 <= side1;
      shp2  <= shp1;
      n2    <= n1;
      t2    <= t1;
      am2   <= am1;
      num2  <= 44'(num_c) * 44'(num_c);
      den2  <= 42'(den_c) * 42'(den_c);
      c5    <= 29'(xx1) * 29'(k_c);
      n3    <= 27'(nn1) * 27'(n1);
      t4    <= 36'(tt1) * 36'(tt1);
      n4    <= 36'(nn1) * 36'(nn1);
    end
  end

  // stage 3
  logic [NW-1:0] num3_c;
  logic [DW-1:0] den3_c;

  always_comb begin
    case (shp2)
      SHAPE_SINE2: begin
        num3_c = NW'(side2.amp) * NW'(num2);
        den3_c = DW'(den2);
      end
      SHAPE_SUP, SHAPE_SDOWN: begin
        num3_c = NW'(side2.amp) * NW'(c5);
        den3_c = DW'(n3);
      end
      default: begin
        num3_c = NW'(am2);
        den3_c = DW'(n2);
      end
    endcase
  end

  side_t         side3;
  shape_t        shp3;
  logic [NW-1:0] num3;
  logic [DW-1:0] den3, t5, n5;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      side3 <= side2;
      shp3  <= shp2;
      num3  <= num3_c;
      den3  <= den3_c;
      t5    <= DW'(t4) * DW'(t2);
      n5    <= DW'(n4) * DW'(n2);
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      side <= side3;
      if (shp3 == SHAPE_EXP) begin
        num <= NW'(side3.amp) * NW'(t5);
        den <= n5;
      end else begin
        num <= num3;
        den <= den3;
      end
    end
  end

  assign out_valid = v[4];

endmodule

FILE: src/lws_div_cell.sv
// one restoring divider cell: settles quotient bit BIT and passes
// the partial remainder on; depends on lws_pkg
module lws_div_cell #(
  parameter int BIT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [lws_pkg::NW-1:0] rem_in,
  input  logic [lws_pkg::DW-1:0] den_in,
  input  logic [lws_pkg::QW-1:0] quo_in,
  input  lws_pkg::side_t         side_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [lws_pkg::NW-1:0] rem_out,
  output logic [lws_pkg::DW-1:0] den_out,
  output logic [lws_pkg::QW-1:0] quo_out,
  output lws_pkg::side_t         side_out
);
  import lws_pkg::*;

  logic [NW-1:0] dsh;
  logic          ge;
  logic [QW-1:0] quo_next;

  always_comb begin
    dsh      = NW'(den_in) << BIT;
    ge       = rem_in >= dsh;
    quo_next = quo_in;
    quo_next[BIT] = ge;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_out  <= ge ? rem_in - dsh : rem_in;
      den_out  <= den_in;
      quo_out  <= quo_next;
      side_out <= side_in;
    end
  end

endmodule
